### sv/mnnd_pkg.sv
// ---------------------------------------------------------------------------
// mnnd_pkg
// Shared types and constants of the mean nearest neighbor distance unit.
// ---------------------------------------------------------------------------
package mnnd_pkg;

    localparam int MNND_MAX_SAMPLES = 64;
    localparam int MNND_COORD_BITS  = 24;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_STREAM = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_NONE   = 2'd3
    } mnnd_action_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_FLUSH,
        ST_ROOT_START,
        ST_ROOT_WAIT,
        ST_DIV,
        ST_OUT
    } mnnd_state_t;

    // Control part of a beat traveling down the cell chain
    typedef struct packed {
        logic vld;
        logic is_load;
        logic taken;
    } mnnd_tok_t;

endpackage

### sv/mnnd_cell.sv
// ---------------------------------------------------------------------------
// mnnd_cell
// One cell of the chain: holds one sample and its least nonzero squared
// distance, registers each beat and forwards it to its neighbor.
// ---------------------------------------------------------------------------
module mnnd_cell
    import mnnd_pkg::*;
#(
    parameter int COORD_BITS = MNND_COORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  mnnd_tok_t                    tok_in,
    input  logic signed [COORD_BITS-1:0] x_in,
    input  logic signed [COORD_BITS-1:0] y_in,
    input  logic signed [COORD_BITS-1:0] z_in,
    output mnnd_tok_t                    tok_out,
    output logic signed [COORD_BITS-1:0] x_out,
    output logic signed [COORD_BITS-1:0] y_out,
    output logic signed [COORD_BITS-1:0] z_out,
    input  logic                         clear,
    input  logic                         shift,
    input  logic [2*COORD_BITS+3:0]      min_in,
    output logic [2*COORD_BITS+3:0]      min_out
);

    localparam int MW = 2 * COORD_BITS + 4;
    localparam int SW = 2 * COORD_BITS + 2;

    mnnd_tok_t                    tok_reg, tok_next;
    logic signed [COORD_BITS-1:0] xo_reg, yo_reg, zo_reg;
    logic signed [COORD_BITS-1:0] sx_reg, sy_reg, sz_reg;
    logic                         valid_reg;
    logic                         cmp_reg;
    logic [SW-1:0]                sqx_reg, sqy_reg, sqz_reg;
    logic [MW-1:0]                min_reg;

    logic                         capture;
    logic                         measure;
    logic signed [COORD_BITS:0]   dx, dy, dz;
    logic signed [2*COORD_BITS+1:0] px, py, pz;
    logic [MW-1:0]                sq_dist;

    // Decide what this beat does here
    assign capture = tok_in.vld && tok_in.is_load && !tok_in.taken && !valid_reg;
    assign measure = tok_in.vld && !tok_in.is_load && valid_reg;

    // Mark a load beat as taken once a cell captures it
    always_comb
    begin
        tok_next       = tok_in;
        tok_next.taken = tok_in.taken | capture;
    end

    // Differences and squares, registered before the sum
    assign dx = {x_in[COORD_BITS-1], x_in} - {sx_reg[COORD_BITS-1], sx_reg};
    assign dy = {y_in[COORD_BITS-1], y_in} - {sy_reg[COORD_BITS-1], sy_reg};
    assign dz = {z_in[COORD_BITS-1], z_in} - {sz_reg[COORD_BITS-1], sz_reg};
    assign px = dx * dx;
    assign py = dy * dy;
    assign pz = dz * dz;

    assign sq_dist = {2'b00, sqx_reg} + {2'b00, sqy_reg} + {2'b00, sqz_reg};

    // Forward the beat and track sample occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
            cmp_reg   <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
            cmp_reg <= measure;
            if (clear)
                valid_reg <= 1'b0;
            else if (capture)
                valid_reg <= 1'b1;
        end
    end

    // Hold payload: coordinates, sample and squares
    always_ff @(posedge clk)
    begin
        xo_reg <= x_in;
        yo_reg <= y_in;
        zo_reg <= z_in;
        if (capture)
        begin
            sx_reg <= x_in;
            sy_reg <= y_in;
            sz_reg <= z_in;
        end
        sqx_reg <= px[SW-1:0];
        sqy_reg <= py[SW-1:0];
        sqz_reg <= pz[SW-1:0];
    end

    // Keep the least nonzero distance; shift toward the head on drain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_reg <= '1;
        else if (shift)
            min_reg <= min_in;
        else if (capture)
            min_reg <= '1;
        else if (cmp_reg && (sq_dist != '0) && (sq_dist < min_reg))
            min_reg <= sq_dist;
    end

    assign tok_out = tok_reg;
    assign x_out   = xo_reg;
    assign y_out   = yo_reg;
    assign z_out   = zo_reg;
    assign min_out = min_reg;

endmodule

### sv/mnnd_isqrt.sv
// ---------------------------------------------------------------------------
// mnnd_isqrt
// Iterative integer square root, one root bit per cycle.
// ---------------------------------------------------------------------------
module mnnd_isqrt
    import mnnd_pkg::*;
#(
    parameter int COORD_BITS = MNND_COORD_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [2*COORD_BITS+3:0]  value,
    output logic                     done,
    output logic [COORD_BITS+1:0]    root
);

    localparam int MW = 2 * COORD_BITS + 4;
    localparam int RW = COORD_BITS + 2;
    localparam int KW = $clog2(RW + 1);

    logic [MW-1:0] val_reg;
    logic [RW+1:0] rem_reg;
    logic [RW-1:0] root_reg;
    logic [KW-1:0] step_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;

    // Bring down the next bit pair and try the next root bit
    assign rem_sh = {rem_reg[RW-1:0], val_reg[MW-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == KW'(RW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg <= {val_reg[MW-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### sv/mean_nearest_neighbour_distance_unit.sv
// ---------------------------------------------------------------------------
// mean_nearest_neighbour_distance_unit
// Mean nearest neighbor distance of loaded samples in a streamed 3D cloud.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries action and coordinates.
// Load beats fill sample cells in order; stream beats are compared against
// every held sample as they walk down the chain of MAX_SAMPLES cells, one
// cell per cycle. Load and stream beats are taken one per cycle while
// no finish is in progress. A finish beat raises in_stall while the chain
// drains, then each held minimum is shifted out to a shared iterative
// square root unit and the root sum is divided by the sample count in a
// restoring divider (one quotient bit per cycle). An empty set skips
// these steps and goes straight to the result.
// The result beat (out_valid / out_stall) is held until taken; in_stall
// stays high meanwhile and the sample set is cleared.
// Reset empties the sample set and drops any pending result.
// ---------------------------------------------------------------------------
module mean_nearest_neighbour_distance_unit
    import mnnd_pkg::*;
#(
    parameter int MAX_SAMPLES = MNND_MAX_SAMPLES,
    parameter int COORD_BITS  = MNND_COORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   action,
    input  logic signed [COORD_BITS-1:0] coord_x,
    input  logic signed [COORD_BITS-1:0] coord_y,
    input  logic signed [COORD_BITS-1:0] coord_z,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [COORD_BITS+1:0]        mean_distance,
    output logic                         unmatched_flag,
    output logic                         empty_flag
);

    localparam int MW  = 2 * COORD_BITS + 4;
    localparam int RW  = COORD_BITS + 2;
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int IW  = $clog2(MAX_SAMPLES + 3);
    localparam int SUW = RW + CW;
    localparam int DW  = $clog2(SUW + 1);

    mnnd_tok_t                    tok   [MAX_SAMPLES+1];
    logic signed [COORD_BITS-1:0] cx    [MAX_SAMPLES+1];
    logic signed [COORD_BITS-1:0] cy    [MAX_SAMPLES+1];
    logic signed [COORD_BITS-1:0] cz    [MAX_SAMPLES+1];
    logic [MW-1:0]                mins  [MAX_SAMPLES+1];

    mnnd_state_t    state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [DW-1:0]  dstep_reg, dstep_next;
    logic [SUW-1:0] sum_reg, sum_next;
    logic [SUW-1:0] quo_reg, quo_next;
    logic [CW:0]    rem_reg, rem_next;
    logic           unm_reg, unm_next;
    logic           empty_reg, empty_next;

    logic           accept;
    logic           clear;
    logic           shift;
    logic           sq_start;
    logic           sq_done;
    logic [RW-1:0]  sq_root;
    logic [CW:0]    rem_sh;

    assign accept = in_valid && !in_stall;

    // Inject beats at the head of the chain
    always_comb
    begin
        tok[0].vld     = accept && (((action == ACT_LOAD) &&
                         (cnt_reg < CW'(MAX_SAMPLES))) || (action == ACT_STREAM));
        tok[0].is_load = (action == ACT_LOAD);
        tok[0].taken   = 1'b0;
    end
    assign cx[0] = coord_x;
    assign cy[0] = coord_y;
    assign cz[0] = coord_z;
    assign mins[MAX_SAMPLES] = '1;

    // Chain of sample cells
    for (genvar i = 0; i < MAX_SAMPLES; i++)
    begin : g_cell
        mnnd_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[i]),
            .x_in    (cx[i]),
            .y_in    (cy[i]),
            .z_in    (cz[i]),
            .tok_out (tok[i+1]),
            .x_out   (cx[i+1]),
            .y_out   (cy[i+1]),
            .z_out   (cz[i+1]),
            .clear   (clear),
            .shift   (shift),
            .min_in  (mins[i+1]),
            .min_out (mins[i])
        );
    end

    // Shared square root unit at the head of the drain
    mnnd_isqrt #(
        .COORD_BITS (COORD_BITS)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (mins[0]),
        .done  (sq_done),
        .root  (sq_root)
    );

    assign rem_sh = {rem_reg[CW-1:0], quo_reg[SUW-1]};

    // Hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            dstep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            dstep_reg <= dstep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        unm_reg   <= unm_next;
        empty_reg <= empty_next;
    end

    // Sequence load, drain, root, divide and output
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        dstep_next = dstep_reg;
        sum_next   = sum_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        unm_next   = unm_reg;
        empty_next = empty_reg;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        clear      = 1'b0;
        shift      = 1'b0;
        sq_start   = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                in_stall = 1'b0;
                if (accept)
                begin
                    if ((action == ACT_LOAD) && (cnt_reg < CW'(MAX_SAMPLES)))
                        cnt_next = cnt_reg + 1'b1;
                    else if (action == ACT_FINISH)
                    begin
                        sum_next = '0;
                        unm_next = 1'b0;
                        idx_next = '0;
                        if (cnt_reg == '0)
                        begin
                            quo_next   = '0;
                            empty_next = 1'b1;
                            state_next = ST_OUT;
                        end
                        else
                        begin
                            empty_next = 1'b0;
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IW'(MAX_SAMPLES + 2))
                begin
                    idx_next   = '0;
                    state_next = ST_ROOT_START;
                end
            end
            ST_ROOT_START:
            begin
                sq_start = 1'b1;
                shift    = 1'b1;
                if (mins[0] == '1)
                    unm_next = 1'b1;
                state_next = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT:
            begin
                if (sq_done)
                begin
                    sum_next = sum_reg + SUW'(sq_root);
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg + 1'b1 == IW'(cnt_reg))
                    begin
                        quo_next   = sum_reg + SUW'(sq_root);
                        rem_next   = '0;
                        dstep_next = '0;
                        state_next = ST_DIV;
                    end
                    else
                        state_next = ST_ROOT_START;
                end
            end
            ST_DIV:
            begin
                if (rem_sh >= {1'b0, cnt_reg})
                begin
                    rem_next = rem_sh - {1'b0, cnt_reg};
                    quo_next = {quo_reg[SUW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[SUW-2:0], 1'b0};
                end
                dstep_next = dstep_reg + 1'b1;
                if (dstep_reg == DW'(SUW - 1))
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                clear     = 1'b1;
                cnt_next  = '0;
                if (!out_stall)
                    state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    assign mean_distance  = quo_reg[RW-1:0];
    assign unmatched_flag = unm_reg;
    assign empty_flag     = empty_reg;

endmodule

### tb/sv/mnnd_checker.sv
// ---------------------------------------------------------------------------
// mnnd_checker
// Watches both channels of the mean nearest neighbor distance unit, keeps
// its own copy of the sample set, predicts each finish result and compares.
// ---------------------------------------------------------------------------
module mnnd_checker
    import mnnd_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic [1:0]                         action,
    input  logic signed [MNND_COORD_BITS-1:0]  coord_x,
    input  logic signed [MNND_COORD_BITS-1:0]  coord_y,
    input  logic signed [MNND_COORD_BITS-1:0]  coord_z,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [MNND_COORD_BITS+1:0]         mean_distance,
    input  logic                               unmatched_flag,
    input  logic                               empty_flag,
    output int                                 fail_count,
    output int                                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = MNND_COORD_BITS;
    localparam int SQ_BITS = 2 * CB + 4;

    typedef struct packed {
        logic [CB+1:0] mean;
        logic          unmatched;
        logic          empty;
    } mean_result_t;

    logic signed [CB-1:0] held_x [MNND_MAX_SAMPLES];
    logic signed [CB-1:0] held_y [MNND_MAX_SAMPLES];
    logic signed [CB-1:0] held_z [MNND_MAX_SAMPLES];
    logic [SQ_BITS-1:0]   nearest_sq [MNND_MAX_SAMPLES];
    int                   held_count;
    mean_result_t         expected_means [$];

    assign pending = expected_means.size();

    // floor square root, one result bit per pass
    function automatic logic [63:0] floor_root(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] t;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= n)
                r = t;
        end
        return r;
    endfunction

    function automatic logic [63:0] abs_sq(logic signed [CB-1:0] a,
                                           logic signed [CB-1:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return 64'(d) * 64'(d);
    endfunction

    // Update the sample set on each input beat, queue finish results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            expected_means.delete();
        end
        else if (in_valid && !in_stall)
        begin
            case (mnnd_action_t'(action))
                ACT_LOAD:
                begin
                    if (held_count < MNND_MAX_SAMPLES)
                    begin
                        held_x[held_count] = coord_x;
                        held_y[held_count] = coord_y;
                        held_z[held_count] = coord_z;
                        nearest_sq[held_count] = '1;
                        held_count++;
                    end
                end
                ACT_STREAM:
                begin
                    for (int i = 0; i < held_count; i++)
                    begin
                        logic [63:0] d;
                        d = abs_sq(coord_x, held_x[i]) + abs_sq(coord_y, held_y[i])
                            + abs_sq(coord_z, held_z[i]);
                        if (d != 0 && d < 64'(nearest_sq[i]))
                            nearest_sq[i] = d[SQ_BITS-1:0];
                    end
                end
                ACT_FINISH:
                begin
                    mean_result_t r;
                    logic [63:0]  total;
                    r = '0;
                    total = 0;
                    if (held_count == 0)
                        r.empty = 1'b1;
                    else
                    begin
                        for (int i = 0; i < held_count; i++)
                        begin
                            if (&nearest_sq[i])
                                r.unmatched = 1'b1;
                            total += floor_root(64'(nearest_sq[i]));
                        end
                        r.mean = (total / 64'(held_count)) & {(CB+2){1'b1}};
                    end
                    held_count = 0;
                    expected_means.push_back(r);
                end
                default:
                    ;
            endcase
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fail_count <= 0;
        else if (out_valid && !out_stall)
        begin
            if (expected_means.size() == 0)
            begin
                $error("unexpected result beat");
                fail_count <= fail_count + 1;
            end
            else
            begin
                mean_result_t e;
                int           bad;
                e = expected_means.pop_front();
                bad = 0;
                if (mean_distance !== e.mean)
                begin
                    $error("mean_distance expected %0d got %0d", e.mean, mean_distance);
                    bad++;
                end
                if (unmatched_flag !== e.unmatched)
                begin
                    $error("unmatched_flag expected %0d got %0d", e.unmatched,
                           unmatched_flag);
                    bad++;
                end
                if (empty_flag !== e.empty)
                begin
                    $error("empty_flag expected %0d got %0d", e.empty, empty_flag);
                    bad++;
                end
                fail_count <= fail_count + bad;
            end
        end
    end

endmodule

### tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Drives load, stream and finish beats into the mean nearest neighbor
// distance unit with random gaps and output stalls; the checker predicts.
// ---------------------------------------------------------------------------
module testbench;
    import mnnd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = MNND_COORD_BITS;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [1:0] action;
    logic signed [CB-1:0] coord_x;
    logic signed [CB-1:0] coord_y;
    logic signed [CB-1:0] coord_z;
    logic out_valid;
    logic out_stall;
    logic [CB+1:0] mean_distance;
    logic unmatched_flag;
    logic empty_flag;
    int fail_count;
    int pending;
    logic [CB-1:0] anchor [3];

    mean_nearest_neighbour_distance_unit uut (.*);

    mnnd_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // Most gaps short, a few long
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 4)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Random output stalls
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 49) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(20, 80)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= ($urandom_range(0, 3) == 0);
        end
    end

    // Present one beat and hold it until taken, then maybe idle
    task automatic send_beat(mnnd_action_t a, logic [CB-1:0] x, logic [CB-1:0] y,
                             logic [CB-1:0] z);
        int g;
        action   <= a;
        coord_x  <= x;
        coord_y  <= y;
        coord_z  <= z;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    function automatic logic [CB-1:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(CB-1){1'b0}}};
            1: return {1'b0, {(CB-1){1'b1}}};
            2: return CB'($urandom);
            default: return CB'($urandom_range(0, 40)) - CB'(20);
        endcase
    endfunction

    // Coordinate near the cluster anchor
    function automatic logic [CB-1:0] near(int k);
        return anchor[k] + CB'($urandom_range(0, 6)) - CB'(3);
    endfunction

    localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

    initial
    begin
        int n;
        int ns;
        in_valid = 1'b0;
        action = ACT_NONE;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty set, ignored action, extremes, exact match, no neighbor
        send_beat(ACT_FINISH, '0, '0, '0);
        send_beat(ACT_NONE, '1, '1, '1);
        send_beat(ACT_LOAD, CMAX, CMAX, CMAX);
        send_beat(ACT_LOAD, CMIN, CMIN, CMIN);
        send_beat(ACT_STREAM, CMAX, CMAX, CMAX);
        send_beat(ACT_STREAM, CMIN, CMAX, CMIN);
        send_beat(ACT_FINISH, '0, '0, '0);
        send_beat(ACT_LOAD, '0, '0, '0);
        send_beat(ACT_STREAM, '0, '0, '0);
        send_beat(ACT_FINISH, '1, '1, '1);
        send_beat(ACT_STREAM, 24'd5, 24'd5, 24'd5);
        send_beat(ACT_LOAD, 24'd1, 24'd2, 24'd3);
        send_beat(ACT_LOAD, 24'd9, 24'd9, 24'd9);
        send_beat(ACT_STREAM, 24'd1, 24'd2, 24'd4);
        send_beat(ACT_FINISH, '0, '0, '0);

        // Full set plus ignored extra loads
        for (int i = 0; i < MNND_MAX_SAMPLES + 2; i++)
            send_beat(ACT_LOAD, rnd_coord(), rnd_coord(), rnd_coord());
        send_beat(ACT_STREAM, rnd_coord(), rnd_coord(), rnd_coord());
        send_beat(ACT_FINISH, '0, '0, '0);

        // Hold off until every expected result has come
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        // Random clustered sessions with some noise
        n = 0;
        while (n < 320)
        begin
            for (int k = 0; k < 3; k++)
                anchor[k] = rnd_coord();
            ns = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64)
                                              : $urandom_range(0, 6);
            for (int i = 0; i < ns; i++)
            begin
                send_beat(ACT_LOAD, near(0), near(1), near(2));
                n++;
            end
            for (int i = $urandom_range(0, 12); i > 0; i--)
            begin
                case ($urandom_range(0, 9))
                    0: send_beat(ACT_NONE, CB'($urandom), CB'($urandom), CB'($urandom));
                    1: send_beat(ACT_LOAD, near(0), near(1), near(2));
                    2: send_beat(ACT_STREAM, rnd_coord(), rnd_coord(), rnd_coord());
                    default: send_beat(ACT_STREAM, near(0), near(1), near(2));
                endcase
                n++;
            end
            send_beat(ACT_FINISH, CB'($urandom), CB'($urandom), CB'($urandom));
            n++;
        end
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("[mean_nearest_neighbour_distance_unit] OK");
        else
            $display("[mean_nearest_neighbour_distance_unit] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[mean_nearest_neighbour_distance_unit] ERROR");
        $finish;
    end

endmodule
